// File: hdl/xst_pkg.sv
`default_nettype none
package xst_pkg;
	localparam int OFFSET_BITS = 32;
	localparam int DEPTH_BITS = 8;
	localparam int MAX_DOCTYPE_PARTS = 4;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	typedef enum logic [3:0] {
		EV_NONE = 4'd0, EV_TEXT = 4'd1, EV_OPEN = 4'd2, EV_ATTR = 4'd3, EV_CLOSE = 4'd4,
		EV_PI = 4'd5, EV_COMMENT = 4'd6, EV_DT_PART = 4'd7, EV_DT_END = 4'd8, EV_END = 4'd9
	} event_kind_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_NO_DOC = 3'd1, ERR_SYNTAX = 3'd2, ERR_DEPTH = 3'd3,
		ERR_UNBAL = 3'd4
	} error_code_t;

	typedef enum logic [1:0] {
		EK_TAG = 2'd0, EK_SELF = 2'd1, EK_XML = 2'd2
	} element_kind_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        has_char;
		logic        final_req;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [31:0] first_start;
		logic [31:0] first_end;
		logic [31:0] second_start;
		logic [31:0] second_end;
		logic        whitespace_only;
		logic [1:0]  doctype_index;
		logic [7:0]  nesting_depth;
		logic [2:0]  error_code;
		logic        last_of_run;
	} out_item_t;

	function automatic logic is_space(input logic [20:0] c);
		return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D;
	endfunction
	function automatic logic is_letter(input logic [20:0] c);
		logic [20:0] l;
		l = c | 21'h20;
		return c > 21'd127 || (l >= 21'h61 && l <= 21'h7A);
	endfunction
	function automatic logic is_name_start(input logic [20:0] c);
		return is_letter(c) || c == 21'h5F || c == 21'h3A;
	endfunction
	function automatic logic is_name_char(input logic [20:0] c);
		return is_name_start(c) || (c >= 21'h30 && c <= 21'h39) || c == 21'h2D || c == 21'h2E;
	endfunction
	function automatic logic [20:0] lower(input logic [20:0] c);
		return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
	endfunction
	function automatic logic [7:0] xml_char(input logic [2:0] i);
		case (i)
			3'd0: return 8'h78;
			3'd1: return 8'h6D;
			default: return 8'h6C;
		endcase
	endfunction
	function automatic logic [7:0] doctype_char(input logic [2:0] i);
		case (i)
			3'd0: return 8'h64;
			3'd1: return 8'h6F;
			3'd2: return 8'h63;
			3'd3: return 8'h74;
			3'd4: return 8'h79;
			3'd5: return 8'h70;
			default: return 8'h65;
		endcase
	endfunction
endpackage
`default_nettype wire

// File: hdl/xst_stream_if.sv
`default_nettype none
interface xst_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/xst_out_queue.sv
`default_nettype none
module xst_out_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [1:0]            push_count,
	input  wire xst_pkg::out_item_t    push_a,
	input  wire xst_pkg::out_item_t    push_b,
	output logic                       can_push,
	xst_stream_if.source               m
);
	import xst_pkg::*;

	out_item_t  mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign can_push = cnt_q <= 3'd2;
	assign pop = m.valid && m.ready;
	assign m.valid = cnt_q != 3'd0;
	assign m.payload = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && push_count != 2'd0) begin
			mem_q[wr_q] <= push_a;
			if (push_count == 2'd2) mem_q[wr_q + 2'd1] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + push_count;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (push ? {1'b0, push_count} : 3'd0) - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: hdl/xml_stream_tokenizer.sv
// XML tokenizer, one Unicode code point per beat.
// in_stream: code_point, has_char, final_req. A beat is taken when valid and
// ready are high at a rising clk edge. out_stream: one event per beat, up to
// two events per input beat, last_of_run marking the last one.
// Each input beat is decoded combinationally by the lexer state machine and
// its events are registered into a four-entry output queue that drives
// out_stream; earlier queued events or a receiver stall can hold them there.
// Throughput is one input beat per cycle as long as the queue has room for two
// events; ready drops only when three or more events are still waiting.
// A final_req beat emits an end event with the status and returns all lexer
// state to its reset values for the next document.
// When the receiver stalls, queued events hold and input stalls once the
// queue is nearly full; nothing is lost.
// arst_n (asynchronous, active low) clears the lexer and empties the queue.
// After a syntax, depth or balance error, characters are dropped until the
// final beat, which reports the error code.
`default_nettype none
module xml_stream_tokenizer (
	input  wire logic    clk,
	input  wire logic    arst_n,
	xst_stream_if.sink   in_stream,
	xst_stream_if.source out_stream
);
	import xst_pkg::*;

	typedef enum logic [23:0] {
		S_READY = 24'd1 << 0, S_TAG_BEGIN = 24'd1 << 1, S_TAG_NAME = 24'd1 << 2,
		S_TAG_INSIDE = 24'd1 << 3, S_ATTR_NAME = 24'd1 << 4, S_ATTR_EQ = 24'd1 << 5,
		S_ATTR_QUOTE = 24'd1 << 6, S_ATTR_VALUE = 24'd1 << 7, S_TAG_END = 24'd1 << 8,
		S_CLOSE = 24'd1 << 9, S_CLOSE_NAME = 24'd1 << 10, S_CLOSE_END = 24'd1 << 11,
		S_QMARK = 24'd1 << 12, S_PI = 24'd1 << 13, S_EXCL = 24'd1 << 14,
		S_DASH2 = 24'd1 << 15, S_DOCT = 24'd1 << 16, S_COMMENT = 24'd1 << 17,
		S_DOCTYPE = 24'd1 << 18, S_DT_NAME = 24'd1 << 19, S_DT_QUOTED = 24'd1 << 20,
		S_ERR_SYN = 24'd1 << 21, S_ERR_DEPTH = 24'd1 << 22, S_ERR_UNBAL = 24'd1 << 23
	} state_t;

	typedef logic [OFFSET_BITS-1:0] off_t;

	state_t                st_q, st_d, st_mid;
	logic [2:0]            mc_q, mc_d;
	off_t                  off_q, off_d, mark_q, mark_d, tns_q, tns_d, tne_q, tne_d;
	off_t                  ans_q, ans_d, ane_q, ane_d, ds_q, ds_d;
	logic                  qd_q, qd_d, sp_q, sp_d;
	element_kind_t         ek_q, ek_d;
	logic [DEPTH_BITS-1:0] dep_q, dep_d;
	logic [2:0]            dtp_q, dtp_d;

	logic       take, can_push, again;
	logic [1:0] n;
	out_item_t  ev [2];
	logic [20:0] c;
	off_t       pos, nxt;

	assign take = in_stream.valid && in_stream.ready;
	assign in_stream.ready = can_push;
	assign c = in_stream.payload.code_point;
	assign pos = off_q;
	assign nxt = off_q + off_t'(1);

	function automatic out_item_t mk(input event_kind_t k, input off_t a, input off_t b,
		input off_t cc, input off_t d, input logic ws, input logic [2:0] di,
		input logic [DEPTH_BITS-1:0] dp);
		out_item_t r;
		r = '0;
		r.event_kind = k;
		r.first_start = 32'(a);
		r.first_end = 32'(b);
		r.second_start = 32'(cc);
		r.second_end = 32'(d);
		r.whitespace_only = ws;
		r.doctype_index = di[1:0];
		r.nesting_depth = 8'(dp);
		return r;
	endfunction

	always_comb begin
		logic is_err;
		error_code_t code;
		out_item_t e;
		st_d = st_q; mc_d = mc_q; off_d = off_q; mark_d = mark_q;
		tns_d = tns_q; tne_d = tne_q; ans_d = ans_q; ane_d = ane_q; ds_d = ds_q;
		qd_d = qd_q; sp_d = sp_q; ek_d = ek_q; dep_d = dep_q; dtp_d = dtp_q;
		n = 2'd0; ev[0] = '0; ev[1] = '0; again = 1'b0; st_mid = st_q;
		e = '0; code = ERR_OK;
		is_err = st_q == S_ERR_SYN || st_q == S_ERR_DEPTH || st_q == S_ERR_UNBAL;
		if (in_stream.payload.has_char && !is_err) begin
			off_d = nxt;
			// first pass; states that re-examine the char set again
			case (st_q)
				S_READY: begin
					if (c == 21'h3C) begin
						if (pos != mark_q) begin
							ev[0] = mk(EV_TEXT, mark_q, pos, '0, '0, sp_q, 3'd0, dep_q);
							n = 2'd1;
						end
						st_mid = S_TAG_BEGIN;
					end else if (!is_space(c)) sp_d = 1'b0;
				end
				S_TAG_BEGIN: begin
					if (is_name_start(c)) begin st_mid = S_TAG_NAME; tns_d = pos; end
					else if (c == 21'h2F) st_mid = S_CLOSE;
					else if (c == 21'h3F) begin st_mid = S_QMARK; ds_d = nxt; mc_d = '0; end
					else if (c == 21'h21) st_mid = S_EXCL;
					else if (!is_space(c)) st_mid = S_ERR_SYN;
				end
				S_TAG_NAME: begin
					if (!is_name_char(c)) begin
						tne_d = pos;
						if (dep_q >= DEPTH_MAX) st_mid = S_ERR_DEPTH;
						else begin
							dep_d = dep_q + 1'b1;
							ek_d = EK_TAG;
							ev[0] = mk(EV_OPEN, tns_q, pos, '0, '0, 1'b0, 3'd0, dep_d);
							n = 2'd1;
							st_mid = S_TAG_INSIDE;
							again = 1'b1;
						end
					end
				end
				S_ATTR_NAME: begin
					if (!is_name_char(c)) begin
						ane_d = pos; st_mid = S_ATTR_EQ; again = 1'b1;
					end
				end
				S_CLOSE_NAME: begin
					if (!is_name_char(c)) begin
						tne_d = pos; st_mid = S_CLOSE_END; again = 1'b1;
					end
				end
				S_DT_NAME: begin
					if (!is_name_char(c)) begin
						if (c == 21'h3E) begin
							ev[0] = mk(EV_DT_END, ds_q, pos, '0, '0, 1'b0, dtp_q, dep_q);
							n = 2'd1;
							dtp_d = dtp_q + 3'd1;
							st_mid = S_READY; mark_d = nxt; sp_d = 1'b1;
						end else begin
							ev[0] = mk(EV_DT_PART, ds_q, pos, '0, '0, 1'b0, dtp_q, dep_q);
							n = 2'd1;
							dtp_d = dtp_q + 3'd1;
							st_mid = S_DOCTYPE; again = 1'b1;
						end
					end
				end
				default: again = 1'b1;
			endcase
			st_d = st_mid;
			// second pass on the resulting state
			if (again) begin
				e = '0;
				case (st_mid)
					S_TAG_INSIDE: begin
						if (!is_space(c)) begin
							if (is_letter(c) || c == 21'h5F) begin ans_d = pos; st_d = S_ATTR_NAME; end
							else if (ek_d == EK_TAG && c == 21'h2F) begin
								ek_d = EK_SELF; st_d = S_TAG_END;
							end else if (ek_d == EK_TAG && c == 21'h3E) begin
								st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
							end else if (ek_d == EK_XML && c == 21'h3F) st_d = S_TAG_END;
							else st_d = S_ERR_SYN;
						end
					end
					S_ATTR_EQ: begin
						if (c == 21'h3D) st_d = S_ATTR_QUOTE;
						else if (!is_space(c)) st_d = S_ERR_SYN;
					end
					S_ATTR_QUOTE: begin
						if (c == 21'h22 || c == 21'h27) begin
							qd_d = c == 21'h22; ds_d = nxt; st_d = S_ATTR_VALUE;
						end else if (!is_space(c)) st_d = S_ERR_SYN;
					end
					S_ATTR_VALUE: begin
						if (c == (qd_q ? 21'h22 : 21'h27)) begin
							e = mk(EV_ATTR, ans_q, ane_q, ds_q, pos, 1'b0, 3'd0, dep_d);
							st_d = S_TAG_INSIDE;
						end
					end
					S_TAG_END: begin
						if (c == 21'h3E) begin
							st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
							if (ek_q == EK_SELF) begin
								if (dep_q != '0) dep_d = dep_q - 1'b1;
								e = mk(EV_CLOSE, tns_q, tne_q, '0, '0, 1'b0, 3'd0, dep_d);
							end
						end else if (!is_space(c)) st_d = S_ERR_SYN;
					end
					S_CLOSE: begin
						if (is_name_start(c)) begin st_d = S_CLOSE_NAME; tns_d = pos; end
						else st_d = S_ERR_SYN;
					end
					S_CLOSE_END: begin
						if (c == 21'h3E) begin
							if (dep_q == '0) st_d = S_ERR_UNBAL;
							else begin
								dep_d = dep_q - 1'b1;
								e = mk(EV_CLOSE, tns_q, tne_d, '0, '0, 1'b0, 3'd0, dep_d);
								st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
							end
						end else if (!is_space(c)) st_d = S_ERR_SYN;
					end
					S_QMARK: begin
						if (mc_q < 3'd3 && lower(c) == {13'd0, xml_char(mc_q)}) mc_d = mc_q + 3'd1;
						else if (mc_q == 3'd3 && is_space(c)) begin
							ek_d = EK_XML; st_d = S_TAG_INSIDE;
						end else begin
							st_d = S_PI; mc_d = (c == 21'h3F) ? 3'd1 : 3'd0;
						end
					end
					S_PI: begin
						if (c == 21'h3E && mc_q == 3'd1) begin
							e = mk(EV_PI, ds_q, pos - off_t'(1), '0, '0, 1'b0, 3'd0, dep_q);
							st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
						end else mc_d = (c == 21'h3F) ? 3'd1 : 3'd0;
					end
					S_EXCL: begin
						if (c == 21'h2D) st_d = S_DASH2;
						else if (lower(c) == 21'h64) begin st_d = S_DOCT; mc_d = 3'd1; end
						else st_d = S_ERR_SYN;
					end
					S_DASH2: begin
						if (c == 21'h2D) begin st_d = S_COMMENT; ds_d = nxt; mc_d = '0; end
						else st_d = S_ERR_SYN;
					end
					S_DOCT: begin
						if (mc_q < 3'd7) begin
							if (lower(c) == {13'd0, doctype_char(mc_q)}) mc_d = mc_q + 3'd1;
							else st_d = S_ERR_SYN;
						end else if (is_space(c)) begin st_d = S_DOCTYPE; dtp_d = '0; end
						else st_d = S_ERR_SYN;
					end
					S_COMMENT: begin
						if (c == 21'h3E && mc_q >= 3'd2) begin
							e = mk(EV_COMMENT, ds_q, pos - off_t'(2), '0, '0, 1'b0, 3'd0, dep_q);
							st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
						end else if (c == 21'h2D) mc_d = (mc_q < 3'd2) ? mc_q + 3'd1 : 3'd2;
						else mc_d = '0;
					end
					S_DOCTYPE: begin
						if (!is_space(c)) begin
							if (c == 21'h3E) begin
								e = mk(EV_DT_END, pos, pos, '0, '0, 1'b0, 3'd0, dep_q);
								st_d = S_READY; mark_d = nxt; sp_d = 1'b1;
							end else if (dtp_d < 3'd2) begin
								if (is_letter(c) || c == 21'h5F) begin st_d = S_DT_NAME; ds_d = pos; end
								else st_d = S_ERR_SYN;
							end else if (c == 21'h22 && dtp_d < 3'(MAX_DOCTYPE_PARTS)) begin
								st_d = S_DT_QUOTED; ds_d = nxt;
							end else st_d = S_ERR_SYN;
						end
					end
					S_DT_QUOTED: begin
						if (c == 21'h22) begin
							e = mk(EV_DT_PART, ds_q, pos, '0, '0, 1'b0, dtp_q, dep_q);
							dtp_d = dtp_q + 3'd1;
							st_d = S_DOCTYPE;
						end
					end
					default: ;
				endcase
				if (e.event_kind != EV_NONE) begin
					if (n == 2'd0) ev[0] = e; else ev[1] = e;
					n = n + 2'd1;
				end
			end
		end
		if (in_stream.payload.final_req) begin
			if (st_d == S_ERR_SYN) code = ERR_SYNTAX;
			else if (st_d == S_ERR_DEPTH) code = ERR_DEPTH;
			else if (st_d == S_ERR_UNBAL) code = ERR_UNBAL;
			else if (off_d == '0) code = ERR_NO_DOC;
			else if (dep_d != '0 || st_d != S_READY) code = ERR_SYNTAX;
			else code = ERR_OK;
			e = mk(EV_END, '0, '0, '0, '0, 1'b0, 3'd0, dep_d);
			e.error_code = code;
			if (n < 2'd2) begin
				if (n == 2'd0) ev[0] = e; else ev[1] = e;
				n = n + 2'd1;
			end else ev[1].error_code = code;
			st_d = S_READY; mc_d = '0; off_d = '0; mark_d = '0; tns_d = '0; tne_d = '0;
			ans_d = '0; ane_d = '0; ds_d = '0; qd_d = 1'b0; ek_d = EK_TAG; dep_d = '0;
			sp_d = 1'b1; dtp_d = '0;
		end
		if (n == 2'd1) ev[0].last_of_run = 1'b1;
		if (n == 2'd2) ev[1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_READY; mc_q <= '0; off_q <= '0; mark_q <= '0; tns_q <= '0;
			tne_q <= '0; ans_q <= '0; ane_q <= '0; ds_q <= '0; qd_q <= 1'b0;
			ek_q <= EK_TAG; dep_q <= '0; sp_q <= 1'b1; dtp_q <= '0;
		end else if (take) begin
			st_q <= st_d; mc_q <= mc_d; off_q <= off_d; mark_q <= mark_d; tns_q <= tns_d;
			tne_q <= tne_d; ans_q <= ans_d; ane_q <= ane_d; ds_q <= ds_d; qd_q <= qd_d;
			ek_q <= ek_d; dep_q <= dep_d; sp_q <= sp_d; dtp_q <= dtp_d;
		end
	end

	xst_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take),
		.push_count (n),
		.push_a     (ev[0]),
		.push_b     (ev[1]),
		.can_push   (can_push),
		.m          (out_stream)
	);

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_final_reset: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_stream.payload.final_req |=> off_q == '0 && dep_q == '0)
		else $error("final beat did not reset");
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ERR_SYN) && !(take && in_stream.payload.final_req) |=> st_q == S_ERR_SYN)
		else $error("error state left early");
`endif
endmodule
`default_nettype wire

// File: test/tb.sv
`default_nettype none
module tb;
	import xst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;

	xst_stream_if #(.payload_t(in_item_t)) in_stream ();
	xst_stream_if #(.payload_t(out_item_t)) out_stream ();

	xml_stream_tokenizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_stream(in_stream.sink),
		.out_stream(out_stream.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef enum int {
		P_READY, P_TAG_BEGIN, P_TAG_NAME, P_TAG_INSIDE, P_ATTR_NAME, P_ATTR_EQ,
		P_ATTR_QUOTE, P_ATTR_VALUE, P_TAG_END, P_CLOSE, P_CLOSE_NAME, P_CLOSE_END,
		P_QMARK, P_PI, P_EXCL, P_DASH2, P_DOCT, P_COMMENT, P_DOCTYPE, P_DT_NAME,
		P_DT_QUOTED, P_ERROR
	} lex_state_t;

	lex_state_t lx_state;
	error_code_t lx_err;
	int unsigned lx_match;
	logic [31:0] lx_pos, lx_mark, lx_tag_s, lx_tag_e, lx_attr_s, lx_attr_e, lx_data;
	bit lx_dquote, lx_all_space;
	element_kind_t lx_kind;
	logic [7:0] lx_depth;
	int unsigned lx_parts;

	in_item_t pending_chars[$];
	out_item_t expected_events[$];
	out_item_t run_events[$];

	function automatic bit letter_c(logic [20:0] c);
		return c > 21'd127 || ((c | 21'h20) >= 21'h61 && (c | 21'h20) <= 21'h7A);
	endfunction
	function automatic bit space_c(logic [20:0] c);
		return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D;
	endfunction
	function automatic bit nstart_c(logic [20:0] c);
		return letter_c(c) || c == 21'h5F || c == 21'h3A;
	endfunction
	function automatic bit nchar_c(logic [20:0] c);
		return nstart_c(c) || (c >= 21'h30 && c <= 21'h39) || c == 21'h2D || c == 21'h2E;
	endfunction
	function automatic logic [20:0] fold_c(logic [20:0] c);
		return (c >= 21'h41 && c <= 21'h5A) ? c + 21'd32 : c;
	endfunction

	task automatic lex_clear();
		lx_state = P_READY; lx_err = ERR_OK; lx_match = 0; lx_pos = 0; lx_mark = 0;
		lx_tag_s = 0; lx_tag_e = 0; lx_attr_s = 0; lx_attr_e = 0; lx_data = 0;
		lx_dquote = 0; lx_kind = EK_TAG; lx_depth = 0; lx_all_space = 1; lx_parts = 0;
	endtask

	task automatic add_event(event_kind_t k, logic [31:0] a, logic [31:0] b,
			logic [31:0] c2, logic [31:0] d, bit ws, int unsigned di);
		out_item_t e;
		e = '0;
		e.event_kind = k; e.first_start = a; e.first_end = b;
		e.second_start = c2; e.second_end = d; e.whitespace_only = ws;
		e.doctype_index = di[1:0]; e.nesting_depth = lx_depth;
		if (run_events.size() < 2) run_events.push_back(e);
	endtask

	task automatic raise(error_code_t code);
		lx_state = P_ERROR;
		lx_err = code;
	endtask

	task automatic back_to_text(logic [31:0] nxt);
		lx_state = P_READY; lx_mark = nxt; lx_all_space = 1;
	endtask

	task automatic lex_char(logic [20:0] c);
		logic [31:0] pos, nxt;
		bit again;
		pos = lx_pos;
		nxt = pos + 1;
		again = 1;
		while (again) begin
			again = 0;
			case (lx_state)
				P_READY: begin
					if (c == "<") begin
						if (pos != lx_mark) add_event(EV_TEXT, lx_mark, pos, 0, 0, lx_all_space, 0);
						lx_state = P_TAG_BEGIN;
					end else if (!space_c(c)) lx_all_space = 0;
				end
				P_TAG_BEGIN: begin
					if (nstart_c(c)) begin lx_state = P_TAG_NAME; lx_tag_s = pos; end
					else if (c == "/") lx_state = P_CLOSE;
					else if (c == "?") begin lx_state = P_QMARK; lx_data = nxt; lx_match = 0; end
					else if (c == "!") lx_state = P_EXCL;
					else if (!space_c(c)) raise(ERR_SYNTAX);
				end
				P_TAG_NAME: begin
					if (!nchar_c(c)) begin
						lx_tag_e = pos;
						if (lx_depth >= DEPTH_MAX) raise(ERR_DEPTH);
						else begin
							lx_depth++;
							lx_kind = EK_TAG;
							add_event(EV_OPEN, lx_tag_s, lx_tag_e, 0, 0, 0, 0);
							lx_state = P_TAG_INSIDE;
							again = 1;
						end
					end
				end
				P_TAG_INSIDE: begin
					if (space_c(c)) ;
					else if (letter_c(c) || c == "_") begin lx_attr_s = pos; lx_state = P_ATTR_NAME; end
					else if (lx_kind == EK_TAG && c == "/") begin lx_kind = EK_SELF; lx_state = P_TAG_END; end
					else if (lx_kind == EK_TAG && c == ">") back_to_text(nxt);
					else if (lx_kind == EK_XML && c == "?") lx_state = P_TAG_END;
					else raise(ERR_SYNTAX);
				end
				P_ATTR_NAME: begin
					if (!nchar_c(c)) begin lx_attr_e = pos; lx_state = P_ATTR_EQ; again = 1; end
				end
				P_ATTR_EQ: begin
					if (c == "=") lx_state = P_ATTR_QUOTE;
					else if (!space_c(c)) raise(ERR_SYNTAX);
				end
				P_ATTR_QUOTE: begin
					if (c == "\"" || c == "'") begin
						lx_dquote = (c == "\""); lx_data = nxt; lx_state = P_ATTR_VALUE;
					end else if (!space_c(c)) raise(ERR_SYNTAX);
				end
				P_ATTR_VALUE: begin
					if (c == (lx_dquote ? 21'h22 : 21'h27)) begin
						add_event(EV_ATTR, lx_attr_s, lx_attr_e, lx_data, pos, 0, 0);
						lx_state = P_TAG_INSIDE;
					end
				end
				P_TAG_END: begin
					if (c == ">") begin
						back_to_text(nxt);
						if (lx_kind == EK_SELF) begin
							if (lx_depth > 0) lx_depth--;
							add_event(EV_CLOSE, lx_tag_s, lx_tag_e, 0, 0, 0, 0);
						end
					end else if (!space_c(c)) raise(ERR_SYNTAX);
				end
				P_CLOSE: begin
					if (nstart_c(c)) begin lx_state = P_CLOSE_NAME; lx_tag_s = pos; end
					else raise(ERR_SYNTAX);
				end
				P_CLOSE_NAME: begin
					if (!nchar_c(c)) begin lx_tag_e = pos; lx_state = P_CLOSE_END; again = 1; end
				end
				P_CLOSE_END: begin
					if (c == ">") begin
						if (lx_depth == 0) raise(ERR_UNBAL);
						else begin
							lx_depth--;
							add_event(EV_CLOSE, lx_tag_s, lx_tag_e, 0, 0, 0, 0);
							back_to_text(nxt);
						end
					end else if (!space_c(c)) raise(ERR_SYNTAX);
				end
				P_QMARK: begin
					if (lx_match < 3 && fold_c(c) == (lx_match == 0 ? 21'h78 :
							lx_match == 1 ? 21'h6D : 21'h6C)) lx_match++;
					else if (lx_match == 3 && space_c(c)) begin lx_kind = EK_XML; lx_state = P_TAG_INSIDE; end
					else begin lx_state = P_PI; lx_match = (c == "?"); end
				end
				P_PI: begin
					if (c == ">" && lx_match == 1) begin
						add_event(EV_PI, lx_data, pos - 1, 0, 0, 0, 0);
						back_to_text(nxt);
					end else lx_match = (c == "?");
				end
				P_EXCL: begin
					if (c == "-") lx_state = P_DASH2;
					else if (fold_c(c) == "d") begin lx_state = P_DOCT; lx_match = 1; end
					else raise(ERR_SYNTAX);
				end
				P_DASH2: begin
					if (c == "-") begin lx_state = P_COMMENT; lx_data = nxt; lx_match = 0; end
					else raise(ERR_SYNTAX);
				end
				P_DOCT: begin
					if (lx_match < 7) begin
						if (fold_c(c) == 21'(doctype_char(3'(lx_match)))) lx_match++;
						else raise(ERR_SYNTAX);
					end else if (space_c(c)) begin lx_state = P_DOCTYPE; lx_parts = 0; end
					else raise(ERR_SYNTAX);
				end
				P_COMMENT: begin
					if (c == ">" && lx_match >= 2) begin
						add_event(EV_COMMENT, lx_data, pos - 2, 0, 0, 0, 0);
						back_to_text(nxt);
					end else if (c == "-") lx_match = lx_match < 2 ? lx_match + 1 : 2;
					else lx_match = 0;
				end
				P_DOCTYPE: begin
					if (space_c(c)) ;
					else if (c == ">") begin
						add_event(EV_DT_END, pos, pos, 0, 0, 0, 0);
						back_to_text(nxt);
					end else if (lx_parts < 2) begin
						if (letter_c(c) || c == "_") begin lx_state = P_DT_NAME; lx_data = pos; end
						else raise(ERR_SYNTAX);
					end else if (c == "\"" && lx_parts < MAX_DOCTYPE_PARTS) begin
						lx_state = P_DT_QUOTED; lx_data = nxt;
					end else raise(ERR_SYNTAX);
				end
				P_DT_NAME: begin
					if (nchar_c(c)) ;
					else if (c == ">") begin
						add_event(EV_DT_END, lx_data, pos, 0, 0, 0, lx_parts);
						lx_parts++;
						back_to_text(nxt);
					end else begin
						add_event(EV_DT_PART, lx_data, pos, 0, 0, 0, lx_parts);
						lx_parts++;
						lx_state = P_DOCTYPE;
						again = 1;
					end
				end
				P_DT_QUOTED: begin
					if (c == "\"") begin
						add_event(EV_DT_PART, lx_data, pos, 0, 0, 0, lx_parts);
						lx_parts++;
						lx_state = P_DOCTYPE;
					end
				end
				default: ;
			endcase
		end
		lx_pos = nxt;
	endtask

	task automatic predict_events(in_item_t it);
		error_code_t code;
		run_events.delete();
		if (it.has_char && lx_state != P_ERROR) lex_char(it.code_point);
		if (it.final_req) begin
			if (lx_state == P_ERROR) code = lx_err;
			else if (lx_pos == 0) code = ERR_NO_DOC;
			else if (lx_depth != 0 || lx_state != P_READY) code = ERR_SYNTAX;
			else code = ERR_OK;
			add_event(EV_END, 0, 0, 0, 0, 0, 0);
			run_events[run_events.size() - 1].error_code = code;
			lex_clear();
		end
		if (run_events.size() > 0) run_events[run_events.size() - 1].last_of_run = 1'b1;
		foreach (run_events[i]) expected_events.push_back(run_events[i]);
	endtask

	// driver
	int gap_left = 0, burst_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_stream.valid <= 1'b0;
			in_stream.payload <= '0;
		end else begin
			if (in_stream.valid && in_stream.ready) predict_events(in_stream.payload);
			if (!in_stream.valid || in_stream.ready) begin
				if (gap_left > 0 || pending_chars.size() == 0) begin
					in_stream.valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					in_stream.valid <= 1'b1;
					in_stream.payload <= pending_chars.pop_front();
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// monitor
	int unsigned stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_e, got;
		if (!arst_n) begin
			out_stream.ready <= 1'b0;
		end else begin
			if (out_stream.valid && out_stream.ready) begin
				got = out_stream.payload;
				if (expected_events.size() == 0) begin
					$error("unexpected event kind %0d", got.event_kind);
					failed = 1'b1;
				end else begin
					exp_e = expected_events.pop_front();
					if (got !== exp_e) begin
						failed = 1'b1;
						if (got.event_kind !== exp_e.event_kind) $error("event_kind exp %0d got %0d", exp_e.event_kind, got.event_kind);
						if (got.first_start !== exp_e.first_start) $error("first_start exp %0d got %0d", exp_e.first_start, got.first_start);
						if (got.first_end !== exp_e.first_end) $error("first_end exp %0d got %0d", exp_e.first_end, got.first_end);
						if (got.second_start !== exp_e.second_start) $error("second_start exp %0d got %0d", exp_e.second_start, got.second_start);
						if (got.second_end !== exp_e.second_end) $error("second_end exp %0d got %0d", exp_e.second_end, got.second_end);
						if (got.whitespace_only !== exp_e.whitespace_only) $error("whitespace_only exp %0d got %0d", exp_e.whitespace_only, got.whitespace_only);
						if (got.doctype_index !== exp_e.doctype_index) $error("doctype_index exp %0d got %0d", exp_e.doctype_index, got.doctype_index);
						if (got.nesting_depth !== exp_e.nesting_depth) $error("nesting_depth exp %0d got %0d", exp_e.nesting_depth, got.nesting_depth);
						if (got.error_code !== exp_e.error_code) $error("error_code exp %0d got %0d", exp_e.error_code, got.error_code);
						if (got.last_of_run !== exp_e.last_of_run) $error("last_of_run exp %0d got %0d", exp_e.last_of_run, got.last_of_run);
					end
				end
			end
			stall_phase++;
			if ((stall_phase / 300) % 3 == 0) out_stream.ready <= 1'b1;
			else if ((stall_phase / 300) % 3 == 1) out_stream.ready <= (stall_phase % 7) < 4;
			else out_stream.ready <= $urandom_range(0, 3) != 0;
		end
	end

	task automatic push_ch(logic [20:0] c, bit fin = 0, bit has = 1);
		in_item_t it;
		it.code_point = c; it.has_char = has; it.final_req = fin;
		pending_chars.push_back(it);
	endtask
	task automatic push_str(string s);
		foreach (s[i]) push_ch(21'(s[i]));
	endtask

	function automatic string pick_name();
		string s, pool;
		int n;
		pool = "abXY_:z9-.";
		s = "";
		n = $urandom_range(1, 4);
		s = {s, string'(pool[$urandom_range(0, 4)])};
		for (int i = 1; i < n; i++) s = {s, string'(pool[$urandom_range(0, 9)])};
		return s;
	endfunction

	function automatic string random_fragment(int depth);
		string q, s;
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? " \n\t" : "hi there";
			1: return {"<!--", $urandom_range(0, 1) ? "x-y" : "-", "-->"};
			2: return {"<?", pick_name(), " a?b?>"};
			3: return {"<", pick_name(), $urandom_range(0, 1) ? "/>" : " />"};
			4: begin
				q = $urandom_range(0, 1) ? "\"" : "'";
				return {"<", pick_name(), " ", pick_name(), " = ", q, "v>", q, ">"};
			end
			5: begin
				s = {"<", pick_name(), ">"};
				if (depth < 3) s = {s, random_fragment(depth + 1)};
				return {s, "</", pick_name(), " >"};
			end
			6: return $urandom_range(0, 1) ? "<!DOCTYPE r PUBLIC \"p\" \"s\">" : "<!doctype r>";
			7: return "<?XmL version='1' ?>";
			8: return "<a b='1' c=\"2\"><c/></a>";
			default: return "x";
		endcase
	endfunction

	initial begin
		string doc;
		string junk;
		lex_clear();
		junk = "<>/?!-=\"' a";

		push_ch(0, 1, 0);
		push_ch(21'h1FFFFF, 0, 0);
		push_str(" t<?xml a='1'?><!DOCTYPE r PUBLIC \"a\" \"b\">");
		push_str("<r x=\"1\"><!---a-->");
		push_ch(21'h1FFFFF);
		push_ch(21'h10FFFF);
		push_str("/><?p d??></r>");
		push_ch(0, 1, 0);
		push_str("</a>x");
		push_ch("y", 1);
		push_str("<a>");
		push_ch("!", 1);
		push_str("<!DOCTYPE r>");
		push_ch("x", 1);
		push_str("<a/ x>");
		push_ch(0, 1, 0);
		push_str("<-");
		push_ch(" ", 1);
		for (int i = 0; i < 256; i++) push_str("<a>");
		push_ch("x", 1);

		while (pending_chars.size() < 950) begin
			doc = "";
			while (doc.len() < $urandom_range(20, 80)) doc = {doc, random_fragment(0)};
			if ($urandom_range(0, 4) == 0) doc[$urandom_range(0, doc.len() - 1)] =
				junk[$urandom_range(0, 10)];
			foreach (doc[i]) begin
				if ($urandom_range(0, 40) == 0) push_ch(0, 0, 0);
				if ($urandom_range(0, 60) == 0) push_ch(21'($urandom_range(0, 21'h1FFFFF)));
				push_ch(21'(doc[i]));
			end
			push_ch(21'($urandom), $urandom_range(0, 1), 1'b1);
		end
		for (int b = 0; b < 21; b++) begin
			push_ch(21'(1) << b);
			push_ch(~(21'(1) << b));
		end
		push_ch(0, 1, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_chars.size() == 0 && !in_stream.valid);
		wait (expected_events.size() == 0);
		repeat (20) @(posedge clk);
		if (!failed && expected_events.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("tb failed");
		$finish;
	end
endmodule
`default_nettype wire
